[sv/alpr_pkg.sv]
// ----------------------------------------------------------------------------
// Alpha recovery package
// Widths, pipeline depth and the stage payload type shared by the alpha
// recovery block, its channel interfaces and its divider stage.
// ----------------------------------------------------------------------------
`default_nettype none

package alpr_pkg;

   // Pixel channel width and the width of 255 times a channel value.
   localparam int PIX_W = 8;
   localparam int NUM_W = 2 * PIX_W;

   // Colour channels that are unpremultiplied in parallel.
   localparam int NUM_CH = 3;

   // Quotient bits resolved in each divider stage, and the number of stages.
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = NUM_W / BITS_PER_STAGE;

   // Full-scale channel value.
   localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

   // Payload of one beat as it moves through the divider pipeline. Each
   // channel carries a partial remainder and a work word which holds the
   // unused numerator bits at the top and the quotient bits found so far
   // at the bottom.
   typedef struct packed {
      logic [PIX_W-1:0]                  alpha;
      logic                              last;
      logic [NUM_CH-1:0][PIX_W-1:0]      rem;
      logic [NUM_CH-1:0][NUM_W-1:0]      work;
   } alpr_div_type;

endpackage : alpr_pkg

`default_nettype wire

[sv/alpr_req_if.sv]
// ----------------------------------------------------------------------------
// Alpha recovery request channel
// Valid/ready channel carrying one pixel over black and channel 0 over white.
// ----------------------------------------------------------------------------
`default_nettype none

interface alpr_req_if
   import alpr_pkg::*;
   ;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] black_ch0;
   logic [PIX_W-1:0] black_ch1;
   logic [PIX_W-1:0] black_ch2;
   logic [PIX_W-1:0] white_ch0;
   logic             last_in;

   modport source (
      output valid, black_ch0, black_ch1, black_ch2, white_ch0, last_in,
      input  ready
   );

   modport sink (
      input  valid, black_ch0, black_ch1, black_ch2, white_ch0, last_in,
      output ready
   );

endinterface : alpr_req_if

`default_nettype wire

[sv/alpr_rsp_if.sv]
// ----------------------------------------------------------------------------
// Alpha recovery response channel
// Valid/ready channel carrying the recovered alpha and unpremultiplied colour.
// ----------------------------------------------------------------------------
`default_nettype none

interface alpr_rsp_if
   import alpr_pkg::*;
   ;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] color_ch0;
   logic [PIX_W-1:0] color_ch1;
   logic [PIX_W-1:0] color_ch2;
   logic [PIX_W-1:0] alpha;
   logic             last_out;

   modport source (
      output valid, color_ch0, color_ch1, color_ch2, alpha, last_out,
      input  ready
   );

   modport sink (
      input  valid, color_ch0, color_ch1, color_ch2, alpha, last_out,
      output ready
   );

endinterface : alpr_rsp_if

`default_nettype wire

[sv/alpr_div_stage.sv]
// ----------------------------------------------------------------------------
// Alpha recovery divider stage
// One registered pipeline stage of a restoring divider. It resolves
// BITS_PER_STAGE quotient bits for every colour channel against the beat's
// alpha, and holds its beat while the stage downstream is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module alpr_div_stage
   import alpr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire alpr_div_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output alpr_div_type      out_data
);

   logic         valid_ff;
   logic         valid_in;
   alpr_div_type data_ff;
   alpr_div_type data_in;

   // The stage can take a beat when it is empty or its beat moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Restoring division steps: shift the next numerator bit into the
   // remainder, subtract alpha when it fits and record the quotient bit.
   always_comb begin
      logic [PIX_W:0]   trial;
      logic [PIX_W-1:0] rem;
      logic [NUM_W-1:0] work;
      logic             qbit;

      data_in = in_data;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         rem  = in_data.rem[ch];
         work = in_data.work[ch];
         for (int step = 0; step < BITS_PER_STAGE; step++) begin
            trial = {rem, work[NUM_W-1]};
            qbit  = (trial >= {1'b0, in_data.alpha});
            if (qbit) begin
               trial = trial - {1'b0, in_data.alpha};
            end
            rem  = trial[PIX_W-1:0];
            work = {work[NUM_W-2:0], qbit};
         end
         data_in.rem[ch]  = rem;
         data_in.work[ch] = work;
      end
   end

   // Valid bit under reset; the payload loads only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule : alpr_div_stage

`default_nettype wire

[sv/alpha_recovery_from_black_white_pair.sv]
// ----------------------------------------------------------------------------
// Alpha recovery from a black/white composite pair
// Recovers alpha as 255 + black_ch0 - white_ch0 (modulo 256) and
// unpremultiplies the black-background colour as 255 * black / alpha,
// keeping the low 8 bits, with zero colour where alpha is zero.
//
//   Channel   Direction  Beat contents
//   req_bus   in         black_ch0, black_ch1, black_ch2, white_ch0, last_in
//   rsp_bus   out        color_ch0, color_ch1, color_ch2, alpha, last_out
//
// One pixel is accepted per cycle unless an rsp_bus stall has filled the pipe.
// Each pixel passes one front stage, which forms alpha and the numerators,
// then eight divider stages that resolve sixteen quotient bits two at a time.
// Reset is synchronous and clears only the stage valid bits.
// A stall on rsp_bus holds each full stage; empty stages still fill, so
// req_bus keeps accepting until every stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_recovery_from_black_white_pair
   import alpr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   alpr_req_if.sink   req_bus,
   alpr_rsp_if.source rsp_bus
);

   // Stage zero is the front stage; stages one on are the divider stages.
   logic         stage_valid [DIV_STAGES+1];
   logic         stage_ready [DIV_STAGES+1];
   alpr_div_type stage_data  [DIV_STAGES+1];

   logic         front_valid_ff;
   logic         front_valid_in;
   alpr_div_type front_data_ff;
   alpr_div_type front_data_in;
   logic         front_ready;
   logic [PIX_W-1:0] alpha_calc;
   alpr_div_type last_data;

   // Front stage: alpha with wrap-around, and 255 * black as (b << 8) - b.
   assign alpha_calc = FULL_SCALE + req_bus.black_ch0 - req_bus.white_ch0;

   always_comb begin
      front_data_in.alpha   = alpha_calc;
      front_data_in.last    = req_bus.last_in;
      front_data_in.rem     = '0;
      front_data_in.work[0] = {req_bus.black_ch0, {PIX_W{1'b0}}}
                              - {{PIX_W{1'b0}}, req_bus.black_ch0};
      front_data_in.work[1] = {req_bus.black_ch1, {PIX_W{1'b0}}}
                              - {{PIX_W{1'b0}}, req_bus.black_ch1};
      front_data_in.work[2] = {req_bus.black_ch2, {PIX_W{1'b0}}}
                              - {{PIX_W{1'b0}}, req_bus.black_ch2};
   end

   assign front_ready    = !front_valid_ff || stage_ready[1];
   assign front_valid_in = front_ready ? req_bus.valid : front_valid_ff;
   assign req_bus.ready  = front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && front_ready) begin
         front_data_ff <= front_data_in;
      end
   end

   assign stage_valid[0] = front_valid_ff;
   assign stage_data[0]  = front_data_ff;
   assign stage_ready[0] = front_ready;

   // Divider stages, each handing its beat to the next.
   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      logic next_ready;

      if (s == DIV_STAGES) begin : g_tail
         assign next_ready = rsp_bus.ready;
      end else begin : g_mid
         assign next_ready = stage_ready[s+1];
      end

      alpr_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s-1]),
         .in_ready  (stage_ready[s]),
         .in_data   (stage_data[s-1]),
         .out_valid (stage_valid[s]),
         .out_ready (next_ready),
         .out_data  (stage_data[s])
      );
   end

   // Response: the low quotient bits, forced to zero where alpha is zero.
   assign last_data         = stage_data[DIV_STAGES];
   assign rsp_bus.valid     = stage_valid[DIV_STAGES];
   assign rsp_bus.alpha     = last_data.alpha;
   assign rsp_bus.last_out  = last_data.last;
   assign rsp_bus.color_ch0 = (last_data.alpha == '0) ? '0 : last_data.work[0][PIX_W-1:0];
   assign rsp_bus.color_ch1 = (last_data.alpha == '0) ? '0 : last_data.work[1][PIX_W-1:0];
   assign rsp_bus.color_ch2 = (last_data.alpha == '0) ? '0 : last_data.work[2][PIX_W-1:0];

   // An accepted pixel's alpha appears in the front stage register in the following cycle.
   a_front_alpha : assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> front_data_ff.alpha == $past(alpha_calc))
      else $error("front stage alpha does not match the accepted pixel");

   // A blocked front stage keeps its beat unchanged.
   a_front_hold : assert property (@(posedge clock) disable iff (reset)
      front_valid_ff && !front_ready |=> front_valid_ff && $stable(front_data_ff))
      else $error("front stage lost or changed a stalled beat");

   // The request side only stalls when the response side is stalled too.
   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready)
      else $error("request stalled without a stalled response");

   // After the last division step every remainder is below a non-zero alpha.
   a_rem_range : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && last_data.alpha != '0 |->
         last_data.rem[0] < last_data.alpha &&
         last_data.rem[1] < last_data.alpha &&
         last_data.rem[2] < last_data.alpha)
      else $error("division remainder not below alpha");

endmodule : alpha_recovery_from_black_white_pair

`default_nettype wire
